>>> sv/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Types and constants shared by the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int CFG_W     = 10;  // width of every timing register
  localparam int CFG_IDX_W = 3;   // width of the register index
  localparam int BYTE_W    = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_RELEASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_START    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_HOLD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_RECOVERY = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd490;
  localparam logic [CFG_W-1:0] RST_RESET_RELEASE = 10'd490;
  localparam logic [CFG_W-1:0] RST_SLOT_START    = 10'd2;
  localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd4;
  localparam logic [CFG_W-1:0] RST_SLOT_HOLD     = 10'd62;
  localparam logic [CFG_W-1:0] RST_SLOT_RECOVERY = 10'd2;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RLOW  = 3'd1,
    PH_RREL  = 3'd2,
    PH_START = 3'd3,
    PH_DATA  = 3'd4,
    PH_TAIL  = 3'd5,
    PH_REC   = 3'd6
  } phase_t;

  typedef struct packed {
    cmd_t              func;
    logic [BYTE_W-1:0] write_data;
    logic              line_level;
  } in_t;

  typedef struct packed {
    logic              pull_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
  } out_t;

endpackage

>>> sv/one_wire_master.sv
// ----------------------------------------------------------------------------
// one_wire_master
// 1-Wire bus master: reset pulse, write byte and read byte commands, timed by
// one microsecond tick per request.
// ----------------------------------------------------------------------------
// Each input request is one timebase tick and gives exactly one result. The
// block takes a request in every cycle unless stalled; the result is in the
// output register in the next cycle. The input is stalled only while that
// register holds a result that the far side is stalling. The command state
// machine, tick timer and bit shifter all update in the cycle the request is
// taken, so the rate is one tick per unstalled clock. A command is taken only
// when idle, its first tick in the same request; func while busy is ignored.
// Bytes go LSB first as eight slots; read bits shift in at bit 7 and
// read_data changes on the done tick of a read. A timing register of zero
// counts as one tick, except the recovery time, where zero leaves the
// recovery phase out. Durations are clipped to 2^TIMER_WIDTH-1 ticks.
// Write configuration only while idle (not enforced). No presence check is made.
// ----------------------------------------------------------------------------
module one_wire_master
  import owm_pkg::*;
#(
  parameter int TIMER_WIDTH = 10  // tick timer width, 9 to 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // common width for clipping a register against the timer range
  localparam int CW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  typedef logic [TIMER_WIDTH-1:0] tmr_t;

  // clip a register to the timer range, zero becomes one unless allowed
  function automatic tmr_t clip(input logic [CFG_W-1:0] v, input logic allow_zero);
    logic [CW-1:0] ve;
    logic [CW-1:0] mx;
    ve = CW'(v);
    mx = CW'({TIMER_WIDTH{1'b1}});
    if (v == '0 && !allow_zero) begin
      ve = CW'(1);
    end
    if (ve > mx) begin
      ve = mx;
    end
    return ve[TIMER_WIDTH-1:0];
  endfunction

  // configuration registers
  logic [CFG_W-1:0] reset_low_r, reset_release_r, slot_start_r;
  logic [CFG_W-1:0] read_sample_r, slot_hold_r, slot_recovery_r;

  // command state
  phase_t            phase_r, phase_nxt;
  cmd_t              cmd_r, cmd_nxt;
  tmr_t              tick_r, tick_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic [BYTE_W-1:0] last_read_r, last_read_nxt;

  // result register
  logic out_valid_r;
  out_t out_data_r;

  // working values for this tick
  logic              in_acc;
  logic              cmd_start;
  phase_t            ph_cur;
  cmd_t              cmd_cur;
  tmr_t              tick_cur, tick_inc, dur;
  logic [2:0]        bit_cur;
  logic [BYTE_W-1:0] shift_cur, shift_s;
  logic              active, last, has_rec, slot_end, finished;
  logic              pull;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a new command only starts from idle
  assign cmd_start = (phase_r == PH_IDLE) && (in_data.func != CMD_NONE);

  always_comb begin
    ph_cur    = phase_r;
    cmd_cur   = cmd_r;
    tick_cur  = tick_r;
    bit_cur   = bit_r;
    shift_cur = shift_r;
    if (cmd_start) begin
      cmd_cur  = in_data.func;
      tick_cur = '0;
      bit_cur  = '0;
      if (in_data.func == CMD_RESET) begin
        ph_cur = PH_RLOW;
      end else begin
        ph_cur    = PH_START;
        shift_cur = (in_data.func == CMD_WRITE) ? in_data.write_data : '0;
      end
    end
  end

  // phase duration and end-of-phase detect
  always_comb begin
    case (ph_cur)
      PH_RLOW:  dur = clip(reset_low_r, 1'b0);
      PH_RREL:  dur = clip(reset_release_r, 1'b0);
      PH_START: dur = clip(slot_start_r, 1'b0);
      PH_DATA:  dur = clip((cmd_cur == CMD_READ) ? read_sample_r : slot_hold_r, 1'b0);
      PH_TAIL:  dur = clip(slot_hold_r, 1'b0);
      PH_REC:   dur = clip(slot_recovery_r, 1'b1);
      default:  dur = tmr_t'(1);
    endcase
  end

  assign active   = (ph_cur != PH_IDLE);
  assign tick_inc = tick_cur + tmr_t'(1);
  assign last     = active && (tick_inc >= dur);
  assign has_rec  = (clip(slot_recovery_r, 1'b1) != '0);

  // a slot ends after the tail, the recovery, or the write data with no recovery
  assign slot_end = last && ((ph_cur == PH_TAIL) || (ph_cur == PH_REC) ||
                    ((ph_cur == PH_DATA) && (cmd_cur != CMD_READ) && !has_rec));
  assign finished = (last && (ph_cur == PH_RREL)) || (slot_end && (bit_cur == 3'd7));

  // read sample at the end of the sample time
  assign shift_s = (last && (ph_cur == PH_DATA) && (cmd_cur == CMD_READ)) ?
                   {in_data.line_level, shift_cur[BYTE_W-1:1]} : shift_cur;

  // next phase
  always_comb begin
    phase_nxt = ph_cur;
    if (finished) begin
      phase_nxt = PH_IDLE;
    end else if (last) begin
      unique case (ph_cur)
        PH_RLOW:  phase_nxt = PH_RREL;
        PH_START: phase_nxt = PH_DATA;
        PH_DATA: begin
          if (cmd_cur == CMD_READ) begin
            phase_nxt = PH_TAIL;
          end else if (has_rec) begin
            phase_nxt = PH_REC;
          end else begin
            phase_nxt = PH_START;
          end
        end
        PH_TAIL, PH_REC: phase_nxt = PH_START;
        default:         phase_nxt = ph_cur;
      endcase
    end
  end

  // bus drive: low during reset pulse and slot start, data bit during write
  always_comb begin
    unique case (ph_cur)
      PH_RLOW, PH_START: pull = 1'b1;
      PH_DATA:           pull = (cmd_cur == CMD_WRITE) ? ~shift_cur[0] : 1'b0;
      default:           pull = 1'b0;
    endcase
  end

  // timer, bit counter, shifter and read byte
  always_comb begin
    tick_nxt      = active ? tick_inc : tick_cur;
    bit_nxt       = bit_cur;
    cmd_nxt       = cmd_cur;
    shift_nxt     = shift_s;
    last_read_nxt = last_read_r;
    if (last) begin
      tick_nxt = '0;
    end
    if (slot_end) begin
      if (cmd_cur == CMD_WRITE) begin
        shift_nxt = shift_s >> 1;
      end
      bit_nxt = bit_cur + 3'd1;
      if (finished && (cmd_cur == CMD_READ)) begin
        last_read_nxt = shift_s;
      end
    end
    if (finished) begin
      tick_nxt = '0;
      bit_nxt  = '0;
      cmd_nxt  = CMD_NONE;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r     <= RST_RESET_LOW;
      reset_release_r <= RST_RESET_RELEASE;
      slot_start_r    <= RST_SLOT_START;
      read_sample_r   <= RST_READ_SAMPLE;
      slot_hold_r     <= RST_SLOT_HOLD;
      slot_recovery_r <= RST_SLOT_RECOVERY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:     reset_low_r     <= cfg_data;
        REG_RESET_RELEASE: reset_release_r <= cfg_data;
        REG_SLOT_START:    slot_start_r    <= cfg_data;
        REG_READ_SAMPLE:   read_sample_r   <= cfg_data;
        REG_SLOT_HOLD:     slot_hold_r     <= cfg_data;
        REG_SLOT_RECOVERY: slot_recovery_r <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // command state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cmd_r       <= CMD_NONE;
      tick_r      <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      last_read_r <= '0;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      cmd_r       <= cmd_nxt;
      tick_r      <= tick_nxt;
      bit_r       <= bit_nxt;
      shift_r     <= shift_nxt;
      last_read_r <= last_read_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r.pull_low  <= pull;
      out_data_r.busy_res  <= active;
      out_data_r.done_res  <= finished;
      out_data_r.read_data <= last_read_nxt;
    end
  end

endmodule

>>> verif/one_wire_master_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_master_tb
// Self-checking bench for the 1-Wire bus master. Tick requests are queued by
// the stimulus process, offered by a clocked driver and predicted one by one
// at acceptance; a clocked monitor compares each result with the oldest
// prediction. Timing registers move through several settings, zero among
// them, with random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module one_wire_master_tb;
  import owm_pkg::*;

  localparam int TIMER_W     = 10;
  localparam int TICK_MAX    = (1 << TIMER_W) - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_AFTER  = 900;   // results seen before the long hold-off
  localparam int HOLD_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  one_wire_master #(.TIMER_WIDTH(TIMER_W)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // tick requests waiting to be offered, and bus outputs waiting to be seen
  in_t  tick_queue[$];
  out_t expected_bus_out[$];

  int ticks_queued = 0;
  int ticks_taken  = 0;
  int results_seen = 0;
  int err_count    = 0;
  bit calm_tail    = 1'b0;  // no idling on either side once set

  // bench copy of the timing registers, changed only while the master is idle
  logic [CFG_W-1:0] timing_reg [0:5];

  // bench copy of the master's sequencing state
  phase_t             bus_phase  = PH_IDLE;
  logic [TIMER_W-1:0] slot_ticks = '0;
  logic [2:0]         bit_no     = '0;
  logic [BYTE_W-1:0]  shift_reg  = '0;
  cmd_t               cmd_active = CMD_NONE;
  logic [BYTE_W-1:0]  read_byte  = '0;

  // ticks a register stands for: zero means one tick, bar recovery where
  // zero drops the phase; long values clip at the timer's full count
  function automatic int reg_ticks(logic [CFG_IDX_W-1:0] idx);
    int n;
    n = int'(timing_reg[idx]);
    if (n == 0 && idx != REG_SLOT_RECOVERY) n = 1;
    if (n > TICK_MAX) n = TICK_MAX;
    return n;
  endfunction

  function automatic int phase_len(phase_t ph);
    case (ph)
      PH_RLOW:  return reg_ticks(REG_RESET_LOW);
      PH_RREL:  return reg_ticks(REG_RESET_RELEASE);
      PH_START: return reg_ticks(REG_SLOT_START);
      PH_DATA:  return (cmd_active == CMD_READ) ? reg_ticks(REG_READ_SAMPLE)
                                                : reg_ticks(REG_SLOT_HOLD);
      PH_TAIL:  return reg_ticks(REG_SLOT_HOLD);
      PH_REC:   return reg_ticks(REG_SLOT_RECOVERY);
      default:  return 1;
    endcase
  endfunction

  // closes a slot; high once the eighth slot of the byte is over
  function automatic bit close_slot();
    if (cmd_active == CMD_WRITE) shift_reg = shift_reg >> 1;
    if (bit_no == 3'd7) begin
      if (cmd_active == CMD_READ) read_byte = shift_reg;
      return 1'b1;
    end
    bit_no    = bit_no + 3'd1;
    bus_phase = PH_START;
    return 1'b0;
  endfunction

  // advances the bench copy by one microsecond tick, gives the bus outputs
  function automatic out_t master_tick(in_t req);
    out_t res;
    bit   last_tick;
    bit   finished;
    res      = '0;
    finished = 1'b0;
    // a command only starts from idle, and its first tick is this one
    if (bus_phase == PH_IDLE && req.func != CMD_NONE) begin
      cmd_active = req.func;
      slot_ticks = '0;
      bit_no     = '0;
      if (req.func == CMD_RESET) begin
        bus_phase = PH_RLOW;
      end else begin
        bus_phase = PH_START;
        shift_reg = (req.func == CMD_WRITE) ? req.write_data : '0;
      end
    end
    if (bus_phase != PH_IDLE) begin
      res.busy_res = 1'b1;
      case (bus_phase)
        PH_RLOW, PH_START: res.pull_low = 1'b1;
        PH_DATA:           res.pull_low = (cmd_active == CMD_WRITE) ? ~shift_reg[0] : 1'b0;
        default:           res.pull_low = 1'b0;
      endcase
      slot_ticks = slot_ticks + 1'b1;
      last_tick  = int'(slot_ticks) >= phase_len(bus_phase);
      // read sample lands on the last tick of the sample window, in at bit 7
      if (bus_phase == PH_DATA && cmd_active == CMD_READ && last_tick)
        shift_reg = {req.line_level, shift_reg[BYTE_W-1:1]};
      if (last_tick) begin
        slot_ticks = '0;
        case (bus_phase)
          PH_RLOW:  bus_phase = PH_RREL;
          PH_RREL:  finished = 1'b1;
          PH_START: bus_phase = PH_DATA;
          PH_DATA: begin
            if (cmd_active == CMD_READ) bus_phase = PH_TAIL;
            else if (phase_len(PH_REC) != 0) bus_phase = PH_REC;
            else finished = close_slot();
          end
          default:  finished = close_slot();
        endcase
      end
      if (finished) begin
        res.done_res = 1'b1;
        bus_phase    = PH_IDLE;
        slot_ticks   = '0;
        bit_no       = '0;
        cmd_active   = CMD_NONE;
      end
    end
    // read byte already carries a read that finished on this tick
    res.read_data = read_byte;
    return res;
  endfunction

  // idling odds in percent, rerolled now and then so calm stretches occur
  function automatic int idle_odds();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // ---------------------------------------------------------------- driver
  int send_gap      = 0;
  int send_idle_pct = 10;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // request taken: predict its outputs now
      if (in_valid && !in_stall) begin
        expected_bus_out.push_back(master_tick(in_data));
        ticks_taken++;
      end
      if ($urandom_range(0, 199) == 0) send_idle_pct = idle_odds();
      // a stalled request stays put, otherwise pick the next move
      if (!in_valid || !in_stall) begin
        if (send_gap > 0 && !calm_tail) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else begin
          in_data  <= tick_queue.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  int  recv_gap      = 0;
  int  recv_idle_pct = 10;
  int  hold_left     = 0;
  bit  hold_done     = 1'b0;
  out_t want;

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_bus_out.size() == 0) begin
          note_error($sformatf("result %0d with nothing expected: %p", results_seen, out_data));
        end else begin
          want = expected_bus_out.pop_front();
          if (out_data.pull_low !== want.pull_low || out_data.busy_res !== want.busy_res ||
              out_data.done_res !== want.done_res || out_data.read_data !== want.read_data)
            note_error($sformatf(
              "result %0d: expected pull %b busy %b done %b byte %h, got %b %b %b %h",
              results_seen, want.pull_low, want.busy_res, want.done_res, want.read_data,
              out_data.pull_low, out_data.busy_res, out_data.done_res, out_data.read_data));
        end
      end
      if ($urandom_range(0, 199) == 0) recv_idle_pct = idle_odds();
      // one long hold-off fills the output register and backs up the input
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && !calm_tail && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (recv_gap > 0 && !calm_tail) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (!calm_tail && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- stimulus
  function automatic void push_tick(cmd_t f, logic [BYTE_W-1:0] d, logic lvl);
    in_t t;
    t.func       = f;
    t.write_data = d;
    t.line_level = lvl;
    tick_queue.push_back(t);
    ticks_queued++;
  endfunction

  // nominal length of a command in ticks under the current timing
  function automatic int cmd_len(cmd_t f);
    case (f)
      CMD_RESET: return reg_ticks(REG_RESET_LOW) + reg_ticks(REG_RESET_RELEASE);
      CMD_WRITE: return 8 * (reg_ticks(REG_SLOT_START) + reg_ticks(REG_SLOT_HOLD) +
                             reg_ticks(REG_SLOT_RECOVERY));
      CMD_READ:  return 8 * (reg_ticks(REG_SLOT_START) + reg_ticks(REG_READ_SAMPLE) +
                             reg_ticks(REG_SLOT_HOLD));
      default:   return 1;
    endcase
  endfunction

  // command tick then plain ticks to cover it; slack shifts the next command
  // early (lands while busy) or late (idle gap); line_sel 2 means random line
  function automatic void queue_command(cmd_t f, logic [BYTE_W-1:0] d, int slack,
                                        int line_sel, bit noisy);
    int   n;
    cmd_t g;
    n = cmd_len(f) - 1 + slack;
    if (n < 0) n = 0;
    push_tick(f, d, (line_sel == 2) ? 1'($urandom_range(0, 1)) : 1'(line_sel));
    repeat (n) begin
      g = (noisy && $urandom_range(0, 15) == 0) ? cmd_t'($urandom_range(0, 3)) : CMD_NONE;
      push_tick(g, 8'($urandom_range(0, 255)),
                (line_sel == 2) ? 1'($urandom_range(0, 1)) : 1'(line_sel));
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    timing_reg[idx] = CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(int lo, int rel, int st, int smp, int hld, int rec);
    write_reg(REG_RESET_LOW, lo);
    write_reg(REG_RESET_RELEASE, rel);
    write_reg(REG_SLOT_START, st);
    write_reg(REG_READ_SAMPLE, smp);
    write_reg(REG_SLOT_HOLD, hld);
    write_reg(REG_SLOT_RECOVERY, rec);
  endtask

  task automatic random_timing(int top);
    set_timing($urandom_range(0, top), $urandom_range(0, top), $urandom_range(0, top),
               $urandom_range(0, top), $urandom_range(0, top), $urandom_range(0, top));
  endtask

  // mostly well-formed commands with random content and timing overlap
  task automatic run_random(int budget);
    int   first;
    int   pick;
    cmd_t f;
    first = ticks_queued;
    while (ticks_queued - first < budget) begin
      pick = $urandom_range(0, 9);
      f    = (pick < 2) ? CMD_RESET : (pick < 6) ? CMD_WRITE : CMD_READ;
      queue_command(f, 8'($urandom_range(0, 255)), int'($urandom_range(0, 6)) - 2, 2, 1'b1);
    end
  endtask

  // all requests taken, master idle, every expected output seen
  task automatic settle();
    while (ticks_taken != ticks_queued || bus_phase != PH_IDLE) begin
      if (ticks_taken == ticks_queued)
        repeat (16) push_tick(CMD_NONE, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
      @(posedge clk);
    end
    while (expected_bus_out.size() != 0) @(posedge clk);
  endtask

  initial begin
    timing_reg[REG_RESET_LOW]     = RST_RESET_LOW;
    timing_reg[REG_RESET_RELEASE] = RST_RESET_RELEASE;
    timing_reg[REG_SLOT_START]    = RST_SLOT_START;
    timing_reg[REG_READ_SAMPLE]   = RST_READ_SAMPLE;
    timing_reg[REG_SLOT_HOLD]     = RST_SLOT_HOLD;
    timing_reg[REG_SLOT_RECOVERY] = RST_SLOT_RECOVERY;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // one read byte on the reset timing
    queue_command(CMD_READ, 8'h00, 1, 2, 1'b0);
    settle();

    // directed: every register at zero, so each phase is a single tick
    // and write recovery drops out
    set_timing(0, 0, 0, 0, 0, 0);
    push_tick(CMD_NONE, 8'hFF, 1'b1);
    push_tick(CMD_NONE, 8'h00, 1'b0);
    queue_command(CMD_RESET, 8'h00, 0, 1, 1'b0);
    queue_command(CMD_WRITE, 8'hFF, 0, 1, 1'b0);
    queue_command(CMD_WRITE, 8'h00, 1, 0, 1'b0);
    queue_command(CMD_READ, 8'hFF, 0, 1, 1'b0);   // all ones from the line
    queue_command(CMD_READ, 8'h00, 0, 0, 1'b0);   // all zeros from the line
    // commands landing mid-byte are dropped, write data included
    queue_command(CMD_WRITE, 8'hA5, -6, 1, 1'b0);
    queue_command(CMD_WRITE, 8'h5A, 0, 1, 1'b0);
    push_tick(CMD_READ, 8'h00, 1'b1);
    push_tick(CMD_RESET, 8'h00, 1'b0);
    queue_command(CMD_READ, 8'h3C, 2, 2, 1'b0);
    settle();

    // random timing, mostly short so many commands fit
    repeat (3) begin
      random_timing(5);
      run_random(200);
      settle();
    end

    random_timing(20);
    run_random(200);
    settle();

    // closing stretch at full rate on both sides
    calm_tail = 1'b1;
    random_timing(4);
    run_random(200);
    settle();
    repeat (4) @(posedge clk);

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  int cycle_no = 0;

  initial begin
    while (cycle_no < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_no++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
sv/owm_pkg.sv
sv/one_wire_master.sv
verif/one_wire_master_tb.sv
